// File: rtl/circular_fifo_with_dump_defines.svh
// Assertion macros used by the back end of the circular queue RTL.
`ifndef CIRCULAR_FIFO_WITH_DUMP_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_DUMP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define CFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define CFD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/cfd_pkg.sv
// Package with the types and constants of the circular queue.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_DISP = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_DISP
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_DUMP
    } back_state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic  valid;
        cmd_t  cmd;
    } cmd_link_t;

endpackage

// File: rtl/cfd_front.sv
// Front end: accepts words, decodes the operation and queues commands.
`timescale 1ns / 1ps

module cfd_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0]                          mode,
    input  logic signed [cfd_pkg::WORD_W-1:0]   value,
    output logic                                busy,
    output cfd_pkg::cmd_link_t                  link,
    input  logic                                pop
);

    cfd_pkg::cmd_t                  q_reg [cfd_pkg::QDEPTH];
    logic [cfd_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [cfd_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [cfd_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [cfd_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [cfd_pkg::QCNT_W-1:0]     count_reg;
    logic [cfd_pkg::QCNT_W-1:0]     count_next;
    cfd_pkg::cmd_t                  cmd_in;
    logic                           known;
    logic                           push;
    logic                           do_pop;

    function automatic logic [cfd_pkg::QPTR_W-1:0] qadv(input logic [cfd_pkg::QPTR_W-1:0] p);
        qadv = (p == cfd_pkg::QPTR_W'(cfd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        cmd_in.value = value;
        cmd_in.op    = cfd_pkg::OP_ENQ;
        known        = 1'b1;
        unique case (cfd_pkg::mode_t'(mode))
            cfd_pkg::MODE_ENQ:  cmd_in.op = cfd_pkg::OP_ENQ;
            cfd_pkg::MODE_DEQ:  cmd_in.op = cfd_pkg::OP_DEQ;
            cfd_pkg::MODE_DISP: cmd_in.op = cfd_pkg::OP_DISP;
            default:            known     = 1'b0;
        endcase
    end

    assign busy       = (count_reg == cfd_pkg::QCNT_W'(cfd_pkg::QDEPTH));
    assign push       = start && !busy && known;
    assign do_pop     = pop && (count_reg != '0);
    assign link.valid = (count_reg != '0);
    assign link.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = do_pop ? qadv(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = push ? qadv(wr_ptr_reg) : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/cfd_back.sv
// Back end: queue storage, pointers, dump sequencer and result register.
`timescale 1ns / 1ps
`include "circular_fifo_with_dump_defines.svh"

module cfd_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cfd_pkg::cmd_link_t                  link,
    output logic                                pop,
    output logic                                strobe,
    output logic [1:0]                          status,
    output logic signed [cfd_pkg::WORD_W-1:0]   data,
    output logic                                last
);

    logic signed [cfd_pkg::WORD_W-1:0]  mem [cfd_pkg::DEPTH];

    cfd_pkg::back_state_t           state_reg;
    cfd_pkg::back_state_t           state_next;
    logic [cfd_pkg::PTR_W-1:0]      head_reg;
    logic [cfd_pkg::PTR_W-1:0]      head_next;
    logic [cfd_pkg::PTR_W-1:0]      tail_reg;
    logic [cfd_pkg::PTR_W-1:0]      tail_next;
    logic [cfd_pkg::CNT_W-1:0]      occ_reg;
    logic [cfd_pkg::CNT_W-1:0]      occ_next;
    logic [cfd_pkg::PTR_W-1:0]      idx_reg;
    logic [cfd_pkg::PTR_W-1:0]      idx_next;
    logic [cfd_pkg::CNT_W-1:0]      left_reg;
    logic [cfd_pkg::CNT_W-1:0]      left_next;
    logic                           strobe_reg;
    logic                           strobe_next;
    cfd_pkg::status_t               status_reg;
    cfd_pkg::status_t               status_next;
    logic signed [cfd_pkg::WORD_W-1:0]  data_reg;
    logic                           last_reg;
    logic                           last_next;
    logic                           wr_en;
    logic                           rd_en;
    logic [cfd_pkg::PTR_W-1:0]      rd_addr;
    logic                           is_full;
    logic                           is_empty;

    function automatic logic [cfd_pkg::PTR_W-1:0] adv(input logic [cfd_pkg::PTR_W-1:0] p);
        adv = (p == cfd_pkg::PTR_W'(cfd_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign is_full  = (occ_reg == cfd_pkg::CNT_W'(cfd_pkg::DEPTH));
    assign is_empty = (occ_reg == '0);
    assign rd_addr  = (state_reg == cfd_pkg::BK_DUMP) ? idx_reg : head_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfd_pkg::BK_IDLE:
            begin
                if (link.valid && (link.cmd.op == cfd_pkg::OP_DISP)
                    && (occ_reg > cfd_pkg::CNT_W'(1)))
                begin
                    state_next = cfd_pkg::BK_DUMP;
                end
            end
            cfd_pkg::BK_DUMP:
            begin
                if (left_reg == cfd_pkg::CNT_W'(1))
                begin
                    state_next = cfd_pkg::BK_IDLE;
                end
            end
            default: state_next = cfd_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        left_next   = left_reg;
        strobe_next = 1'b0;
        status_next = cfd_pkg::STAT_OK;
        last_next   = 1'b1;
        unique case (state_reg)
            cfd_pkg::BK_IDLE:
            begin
                if (link.valid)
                begin
                    pop         = 1'b1;
                    strobe_next = 1'b1;
                    unique case (link.cmd.op)
                        cfd_pkg::OP_ENQ:
                        begin
                            if (is_full)
                            begin
                                status_next = cfd_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                tail_next = adv(tail_reg);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        cfd_pkg::OP_DEQ:
                        begin
                            if (is_empty)
                            begin
                                status_next = cfd_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                occ_next = occ_reg - 1'b1;
                                if (occ_reg == cfd_pkg::CNT_W'(1))
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else
                                begin
                                    head_next = adv(head_reg);
                                end
                            end
                        end
                        cfd_pkg::OP_DISP:
                        begin
                            if (is_empty)
                            begin
                                status_next = cfd_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en     = 1'b1;
                                last_next = (occ_reg == cfd_pkg::CNT_W'(1));
                                idx_next  = adv(head_reg);
                                left_next = occ_reg - 1'b1;
                            end
                        end
                        default: strobe_next = 1'b0;
                    endcase
                end
            end
            cfd_pkg::BK_DUMP:
            begin
                strobe_next = 1'b1;
                rd_en       = 1'b1;
                last_next   = (left_reg == cfd_pkg::CNT_W'(1));
                idx_next    = adv(idx_reg);
                left_next   = left_reg - 1'b1;
            end
            default: strobe_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cfd_pkg::BK_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            occ_reg    <= '0;
            idx_reg    <= '0;
            left_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            idx_reg    <= idx_next;
            left_reg   <= left_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        last_reg   <= last_next;
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
        else
        begin
            data_reg <= '0;
        end
        if (wr_en)
        begin
            mem[tail_reg] <= link.cmd.value;
        end
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

    `CFD_NEVER(a_occ_range, occ_reg > cfd_pkg::CNT_W'(cfd_pkg::DEPTH), "Occupancy exceeds depth.")
    `CFD_NEVER(a_pop_in_dump, pop && (state_reg == cfd_pkg::BK_DUMP), "Command taken during a dump.")
    `CFD_NEVER(a_dump_left, (state_reg == cfd_pkg::BK_DUMP) && (left_reg == '0), "Dump with nothing left.")
    `CFD_ASSERT(a_dump_stable, (state_reg == cfd_pkg::BK_DUMP) |=> $stable(occ_reg), "Dump changed occupancy.")
    `CFD_ASSERT(a_dump_strobe, (state_reg == cfd_pkg::BK_DUMP) |=> strobe_reg, "Dump cycle gave no word.")

endmodule

// File: rtl/circular_fifo_with_dump.sv
// Top level of the circular queue with dump: front end, command queue and back end.
// A command word is stored in the command queue, then taken by the back end, whose
// output registers give its result. A display of n stored words gives n strobed
// words (one EMPTY strobe when empty); the back end takes no command meanwhile.
// busy rises only while the two-entry command queue is full.
// Reset empties the queue and the command queue at once; no clearing pass.
`timescale 1ns / 1ps

module circular_fifo_with_dump
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          mode,
    input  logic signed [cfd_pkg::WORD_W-1:0]   value,
    output logic                                strobe,
    output logic [1:0]                          status,
    output logic signed [cfd_pkg::WORD_W-1:0]   data,
    output logic                                last
);

    cfd_pkg::cmd_link_t link;
    logic               pop;

    cfd_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .value (value),
        .busy  (busy),
        .link  (link),
        .pop   (pop)
    );

    cfd_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .link   (link),
        .pop    (pop),
        .strobe (strobe),
        .status (status),
        .data   (data),
        .last   (last)
    );

endmodule
